/* rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, register map and configuration type of the stereo
// ping-pong delay.
// ----------------------------------------------------------------------------
package spd_pkg;

	// default sizes
	localparam int LINE_DEPTH_DEF  = 16384;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration port
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_FEEDBACK    = 3'd0;
	localparam logic [2:0] REG_DELAY_LEFT  = 3'd1;
	localparam logic [2:0] REG_DELAY_RIGHT = 3'd2;
	localparam logic [2:0] REG_DRY_LVL     = 3'd3;
	localparam logic [2:0] REG_WET_LVL     = 3'd4;

	// reset values
	localparam logic [15:0] FEEDBACK_RST = 16'd0;
	localparam logic [14:0] DELAY_RST    = 15'd10000;
	localparam logic [15:0] DRY_RST      = 16'd32768;
	localparam logic [15:0] WET_RST      = 16'd0;

	typedef struct packed {
		logic signed [15:0] feedback;
		logic [14:0]        delay_left;
		logic [14:0]        delay_right;
		logic [15:0]        dry_lvl;
		logic [15:0]        wet_lvl;
	} cfg_t;

endpackage

/* rtl/spd_in_if.sv */
// ----------------------------------------------------------------------------
// spd_in_if
// Valid/ready channel carrying one stereo input sample pair.
// ----------------------------------------------------------------------------
interface spd_in_if #(
	parameter int SAMPLE_BITS = spd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_left;
	logic signed [SAMPLE_BITS-1:0] in_right;

	modport source (output valid, output in_left, output in_right, input ready);
	modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

/* rtl/spd_out_if.sv */
// ----------------------------------------------------------------------------
// spd_out_if
// Valid/ready channel carrying one stereo output sample pair.
// ----------------------------------------------------------------------------
interface spd_out_if #(
	parameter int SAMPLE_BITS = spd_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_left;
	logic signed [SAMPLE_BITS-1:0] out_right;

	modport source (output valid, output out_left, output out_right, input ready);
	modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

/* rtl/stereo_ping_pong_delay.sv */
// ----------------------------------------------------------------------------
// stereo_ping_pong_delay
// Stereo ping-pong delay with cross feedback between two circular lines.
// ----------------------------------------------------------------------------
// After reset the block clears both delay lines, one entry per cycle, over
// all LINE_DEPTH entries (16384 by default) and takes no sample pair until that
// pass is done; register writes are taken throughout. A processed pair then
// goes from input transfer to result as follows: the transfer cycle reads
// both lines, and seven steps follow through one shared sample-by-17-bit
// multiplier (feedback, dry and wet product per channel) and the final
// saturating add. With the wet gain at zero the pair skips the multiplies
// and passes straight through. The result waits in an output register, so
// the next pair is taken while it is pending. Registers on APB at byte
// addresses 0x00 feedback, 0x04 left delay, 0x08 right delay, 0x0C dry
// gain, 0x10 wet gain; write them only while the block is idle.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay #(
	parameter int LINE_DEPTH  = spd_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = spd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	spd_in_if.sink                     samples,
	spd_out_if.source                  mixed,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spd_pkg::CFG_AW-1:0] paddr,
	input  logic [spd_pkg::CFG_DW-1:0] pwdata,
	output logic [spd_pkg::CFG_DW-1:0] prdata,
	output logic                       pready
);
	spd_pkg::cfg_t cfg;

	// configuration registers
	spd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// delay lines and processing
	spd_core #(
		.LINE_DEPTH  (LINE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.samples (samples),
		.mixed   (mixed)
	);
endmodule

/* rtl/spd_ram.sv */
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/spd_regs.sv */
// ----------------------------------------------------------------------------
// spd_regs
// APB configuration registers: feedback, delay lengths, dry and wet gain.
// ----------------------------------------------------------------------------
module spd_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [spd_pkg::CFG_AW-1:0] paddr,
	input  logic [spd_pkg::CFG_DW-1:0] pwdata,
	output logic [spd_pkg::CFG_DW-1:0] prdata,
	output logic                       pready,
	output spd_pkg::cfg_t              cfg
);
	spd_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feedback    <= spd_pkg::FEEDBACK_RST;
			cfg_q.delay_left  <= spd_pkg::DELAY_RST;
			cfg_q.delay_right <= spd_pkg::DELAY_RST;
			cfg_q.dry_lvl     <= spd_pkg::DRY_RST;
			cfg_q.wet_lvl     <= spd_pkg::WET_RST;
		end else if (wr_en) begin
			unique case (idx)
				spd_pkg::REG_FEEDBACK:    cfg_q.feedback    <= pwdata[15:0];
				spd_pkg::REG_DELAY_LEFT:  cfg_q.delay_left  <= pwdata[14:0];
				spd_pkg::REG_DELAY_RIGHT: cfg_q.delay_right <= pwdata[14:0];
				spd_pkg::REG_DRY_LVL:     cfg_q.dry_lvl     <= pwdata[15:0];
				spd_pkg::REG_WET_LVL:     cfg_q.wet_lvl     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			spd_pkg::REG_FEEDBACK:    prdata = {16'd0, cfg_q.feedback};
			spd_pkg::REG_DELAY_LEFT:  prdata = {17'd0, cfg_q.delay_left};
			spd_pkg::REG_DELAY_RIGHT: prdata = {17'd0, cfg_q.delay_right};
			spd_pkg::REG_DRY_LVL:     prdata = {16'd0, cfg_q.dry_lvl};
			spd_pkg::REG_WET_LVL:     prdata = {16'd0, cfg_q.wet_lvl};
			default:                  prdata = '0;
		endcase
	end
endmodule

/* rtl/spd_core.sv */
// ----------------------------------------------------------------------------
// spd_core
// Sequencer and datapath: two delay-line RAMs, one shared multiplier, and
// the read-modify-write of both lines for each processed stereo pair.
// ----------------------------------------------------------------------------
module spd_core #(
	parameter int LINE_DEPTH  = spd_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = spd_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  spd_pkg::cfg_t cfg,
	spd_in_if.sink        samples,
	spd_out_if.source     mixed
);
	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int LW = $clog2(LINE_DEPTH + 1);
	localparam int PW = SB + 17;       // product width
	localparam int TW = PW - 15;       // product scaled by 2^-15
	localparam int SW = SB + 3;        // sum before saturation

	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

	// sequencer states
	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_FBL  = 4'd2;
	localparam logic [3:0] ST_DRYL = 4'd3;
	localparam logic [3:0] ST_WETL = 4'd4;
	localparam logic [3:0] ST_FBR  = 4'd5;
	localparam logic [3:0] ST_DRYR = 4'd6;
	localparam logic [3:0] ST_WETR = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]           state_q;
	logic [AW-1:0]        clr_q;
	logic [AW-1:0]        lp_q;
	logic [AW-1:0]        rp_q;
	logic                 byp_q;
	logic signed [SB-1:0] xl_q;
	logic signed [SB-1:0] xr_q;
	logic signed [SB-1:0] ll_q;
	logic signed [SB-1:0] w_q;
	logic signed [SB-1:0] yl_q;
	logic signed [TW-1:0] acc_q;
	logic signed [PW-1:0] prod_q;
	logic                 out_valid_q;
	logic signed [SB-1:0] out_l_q;
	logic signed [SB-1:0] out_r_q;

	logic [LW-1:0]        len_l;
	logic [LW-1:0]        len_r;
	logic [AW-1:0]        lp_nxt;
	logic [AW-1:0]        rp_nxt;
	logic                 fwd;
	logic signed [SB-1:0] mul_a;
	logic signed [16:0]   mul_b;
	logic signed [PW-1:0] mul_p;
	logic                 mul_en;
	logic signed [TW-1:0] tq;
	logic signed [SB-1:0] w_new;
	logic signed [SB-1:0] y_new;
	logic                 accept;
	logic                 out_free;
	logic                 clearing;

	logic                 l_we;
	logic [AW-1:0]        l_waddr;
	logic [SB-1:0]        l_wdata;
	logic [SB-1:0]        l_rdata;
	logic                 r_we;
	logic [AW-1:0]        r_waddr;
	logic [SB-1:0]        r_wdata;
	logic [SB-1:0]        r_rdata;
	logic                 rd_en;

	// effective line length: zero acts as one, clamp to the line depth
	function automatic logic [LW-1:0] eff_len(input logic [14:0] d);
		logic [31:0] dx;
		logic [31:0] r;
		dx = {17'd0, d};
		if (dx == 32'd0) begin
			r = 32'd1;
		end else if (dx > 32'(LINE_DEPTH)) begin
			r = 32'(LINE_DEPTH);
		end else begin
			r = dx;
		end
		return r[LW-1:0];
	endfunction

	// position advance with wrap at the length
	function automatic logic [AW-1:0] adv_pos(input logic [AW-1:0] p, input logic [LW-1:0] len);
		logic [31:0] n;
		n = 32'(p) + 32'd1;
		if (n >= 32'(len)) begin
			return '0;
		end
		return n[AW-1:0];
	endfunction

	// saturate a widened sum to the sample range
	function automatic logic signed [SB-1:0] sat(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		if (v > SMAX) begin
			c = SMAX;
		end else if (v < SMIN) begin
			c = SMIN;
		end else begin
			c = v;
		end
		return c[SB-1:0];
	endfunction

	assign len_l  = eff_len(cfg.delay_left);
	assign len_r  = eff_len(cfg.delay_right);
	assign lp_nxt = adv_pos(lp_q, len_l);
	assign rp_nxt = adv_pos(rp_q, len_r);
	// a one-sample left line reads back the sample just written
	assign fwd    = (lp_nxt == lp_q);

	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_valid_q || mixed.ready;
	assign clearing = (state_q == ST_CLR);

	assign samples.ready   = (state_q == ST_IDLE);
	assign mixed.valid     = out_valid_q;
	assign mixed.out_left  = out_l_q;
	assign mixed.out_right = out_r_q;

	// product scaled by 2^-15, rounded toward zero
	assign tq = prod_q[PW-1:15] + TW'(prod_q[PW-1] && (|prod_q[14:0]));

	// new line sample and new output sample from the current product
	always_comb begin
		w_new = '0;
		y_new = '0;
		unique case (state_q)
			ST_DRYL: w_new = sat(SW'(tq) + SW'(xl_q));
			ST_DRYR: w_new = sat(SW'(tq) + SW'(xr_q));
			ST_FBR,
			ST_FIN:  y_new = sat(SW'(acc_q) + SW'(tq));
			default: ;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (state_q)
			ST_FBL:  begin mul_a = $signed(r_rdata); mul_b = 17'(cfg.feedback); end
			ST_DRYL: begin mul_a = xl_q; mul_b = $signed({1'b0, cfg.dry_lvl}); end
			ST_WETL: begin mul_a = w_q;  mul_b = $signed({1'b0, cfg.wet_lvl}); end
			ST_FBR:  begin mul_a = ll_q; mul_b = 17'(cfg.feedback); end
			ST_DRYR: begin mul_a = xr_q; mul_b = $signed({1'b0, cfg.dry_lvl}); end
			ST_WETR: begin mul_a = w_q;  mul_b = $signed({1'b0, cfg.wet_lvl}); end
			default: mul_en = 1'b0;
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// delay-line ports: clearing pass, else one write per channel
	assign rd_en   = (state_q == ST_IDLE);
	assign l_we    = clearing || (state_q == ST_DRYL);
	assign l_waddr = clearing ? clr_q : lp_q;
	assign l_wdata = clearing ? '0 : w_new;
	assign r_we    = clearing || (state_q == ST_DRYR);
	assign r_waddr = clearing ? clr_q : rp_q;
	assign r_wdata = clearing ? '0 : w_new;

	spd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_left_line (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (rd_en),
		.raddr (lp_nxt),
		.rdata (l_rdata)
	);

	spd_ram #(.WIDTH(SB), .DEPTH(LINE_DEPTH)) u_right_line (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (rd_en),
		.raddr (rp_q),
		.rdata (r_rdata)
	);

	// sequencer and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			lp_q        <= '0;
			rp_q        <= '0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded by the final step, else emptied by a transfer
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (mixed.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(LINE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						byp_q   <= (cfg.wet_lvl == '0);
						state_q <= (cfg.wet_lvl == '0) ? ST_FIN : ST_FBL;
					end
				end
				ST_FBL:  state_q <= ST_DRYL;
				ST_DRYL: state_q <= ST_WETL;
				ST_WETL: state_q <= ST_FBR;
				ST_FBR:  state_q <= ST_DRYR;
				ST_DRYR: state_q <= ST_WETR;
				ST_WETR: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (!byp_q) begin
							lp_q <= lp_nxt;
							rp_q <= rp_nxt;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			xl_q <= samples.in_left;
			xr_q <= samples.in_right;
		end
		if (mul_en) begin
			prod_q <= mul_p;
		end
		case (state_q)
			ST_FBL:  ll_q <= $signed(l_rdata);
			ST_DRYL: begin
				w_q <= w_new;
				if (fwd) begin
					ll_q <= w_new;
				end
			end
			ST_WETL: acc_q <= tq;
			ST_FBR:  yl_q  <= y_new;
			ST_DRYR: w_q   <= w_new;
			ST_WETR: acc_q <= tq;
			ST_FIN: begin
				if (out_free) begin
					out_l_q <= byp_q ? xl_q : yl_q;
					out_r_q <= byp_q ? xr_q : y_new;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// an accepted pair goes to the first multiply or, in bypass, straight out
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_FBL || state_q == ST_FIN))
		else $error("spd_core: bad state after input transfer");

	// a result is only ever raised from the final step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("spd_core: output raised outside final step");

	// bypass leaves both positions untouched
	a_bypass_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && byp_q) |=> ($stable(lp_q) && $stable(rp_q)))
		else $error("spd_core: position moved on bypass");

	// positions stay inside the lines
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(lp_q) < 32'(LINE_DEPTH)) && (32'(rp_q) < 32'(LINE_DEPTH)))
		else $error("spd_core: position beyond line depth");
`endif
endmodule
